// File: rtl/grs_pkg.sv
package grs_pkg;

   localparam int MAX_GROUP = 16;
   localparam int DATA_W    = 32;
   localparam int CSR_W     = 5;
   localparam int ADDR_W    = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
   localparam int CNT_W     = $clog2(MAX_GROUP + 1);

   typedef logic signed [DATA_W-1:0] grs_data_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_LOAD
   } grs_state_type;

   // sequencer -> output stage
   typedef struct packed {
      logic load;
      logic list_done;
      logic last_of_run;
   } grs_out_ctl_type;

endpackage

// File: rtl/grs_req_if.sv
interface grs_req_if import grs_pkg::*; ();
   logic         valid;
   logic         ready;
   grs_data_type value;
   logic         end_of_list;

   modport source (output valid, value, end_of_list, input ready);
   modport sink   (input valid, value, end_of_list, output ready);
endinterface

// File: rtl/grs_rsp_if.sv
interface grs_rsp_if import grs_pkg::*; ();
   logic         valid;
   logic         ready;
   grs_data_type out_value;
   logic         list_done;
   logic         last_of_run;

   modport source (output valid, out_value, list_done, last_of_run, input ready);
   modport sink   (input valid, out_value, list_done, last_of_run, output ready);
endinterface

// File: rtl/grs_csr_if.sv
interface grs_csr_if import grs_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CSR_W-1:0] group_size;

   modport source (output valid, group_size, input ready);
   modport sink   (input valid, group_size, output ready);
endinterface

// File: rtl/group_reverse_stream.sv
// Channel  Dir  Payload                                  Accepted when
// req_if   in   value[31:0] s, end_of_list               valid && ready
// rsp_if   out  out_value[31:0] s, list_done, last_of_run valid && ready
// csr_if   in   group_size[4:0]                          valid && ready (ready tied high)
//
// A word that does not close a group is written and counted; req_if.ready stays high.
// A word that closes a group (or ends the list) is written, then one RAM read is
// issued, then one result per cycle leaves the group RAM while rsp_if does not stall.
// The RAM read port sets that pace; rsp_if back-pressure stalls the drain, not the
// result already registered. Reset is synchronous: fill count cleared, group_size = 1.
// The group RAM has no reset; only entries written in the current group are read.
module group_reverse_stream import grs_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   grs_req_if.sink   req_if,
   grs_rsp_if.source rsp_if,
   grs_csr_if.sink   csr_if
);

   grs_out_ctl_type   out_ctl;
   logic              out_free;
   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic              ram_rd_en;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic [DATA_W-1:0] ram_rd_data;

   // fill, drain sequencing and the group_size register
   grs_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .csr_if      (csr_if),
      .out_free    (out_free),
      .out_ctl     (out_ctl),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr)
   );

   // group buffer: one write, one registered read per cycle
   grs_ram #(
      .WIDTH (DATA_W),
      .DEPTH (MAX_GROUP)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (req_if.value),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // result register; holds a word while rsp_if stalls
   grs_out_stage u_out (
      .clock    (clock),
      .reset    (reset),
      .out_ctl  (out_ctl),
      .rd_data  (grs_data_type'(ram_rd_data)),
      .out_free (out_free),
      .rsp_if   (rsp_if)
   );

endmodule

// File: rtl/grs_ram.sv
module grs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/grs_seq.sv
module grs_seq import grs_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   grs_req_if.sink           req_if,
   grs_csr_if.sink           csr_if,
   input  logic              out_free,
   output grs_out_ctl_type   out_ctl,
   output logic              ram_wr_en,
   output logic [ADDR_W-1:0] ram_wr_addr,
   output logic              ram_rd_en,
   output logic [ADDR_W-1:0] ram_rd_addr
);

   grs_state_type    state_ff, state_in;
   logic [CSR_W-1:0] group_size_ff;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0] rem_ff, rem_in;
   logic [ADDR_W-1:0] addr_ff, addr_in, addr_next;
   logic             rev_ff, rev_in;
   logic             eol_ff, eol_in;
   logic [CNT_W-1:0] k_eff;
   logic [CNT_W-1:0] n_cnt;
   logic             req_accept;
   logic             full_group;
   logic             last_word;

   always_comb begin
      if (group_size_ff == '0) begin
         k_eff = CNT_W'(1);
      end else if (int'(group_size_ff) > MAX_GROUP) begin
         k_eff = CNT_W'(MAX_GROUP);
      end else begin
         k_eff = CNT_W'(group_size_ff);
      end
   end

   assign req_if.ready = (state_ff == ST_IDLE);
   assign csr_if.ready = 1'b1;
   assign req_accept  = req_if.valid && (state_ff == ST_IDLE);
   assign n_cnt       = fill_ff + CNT_W'(1);
   assign full_group  = (n_cnt >= k_eff);
   assign last_word   = (rem_ff == CNT_W'(1));
   assign addr_next   = rev_ff ? (addr_ff - ADDR_W'(1)) : (addr_ff + ADDR_W'(1));

   assign ram_wr_en   = req_accept;
   assign ram_wr_addr = fill_ff[ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         group_size_ff <= CSR_W'(1);
         fill_ff       <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         if (csr_if.valid) begin
            group_size_ff <= csr_if.group_size;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      addr_ff <= addr_in;
      rev_ff  <= rev_in;
      eol_ff  <= eol_in;
   end

   always_comb begin
      state_in    = state_ff;
      fill_in     = fill_ff;
      rem_in      = rem_ff;
      addr_in     = addr_ff;
      rev_in      = rev_ff;
      eol_in      = eol_ff;
      ram_rd_en   = 1'b0;
      ram_rd_addr = addr_ff;
      out_ctl     = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (full_group || req_if.end_of_list) begin
                  // full group: reversed drain starts at the word just written; end of list: forward from entry 0
                  rem_in   = n_cnt;
                  rev_in   = full_group;
                  eol_in   = req_if.end_of_list;
                  addr_in  = full_group ? fill_ff[ADDR_W-1:0] : '0;
                  fill_in  = '0;
                  state_in = ST_ISSUE;
               end else begin
                  fill_in = n_cnt;
               end
            end
         end
         ST_ISSUE: begin
            ram_rd_en = 1'b1;
            state_in  = ST_LOAD;
         end
         ST_LOAD: begin
            if (out_free) begin
               out_ctl.load        = 1'b1;
               out_ctl.last_of_run = last_word;
               out_ctl.list_done   = last_word && eol_ff;
               if (last_word) begin
                  state_in = ST_IDLE;
               end else begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = addr_next;
                  addr_in     = addr_next;
                  rem_in      = rem_ff - CNT_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// File: rtl/grs_out_stage.sv
module grs_out_stage import grs_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  grs_out_ctl_type out_ctl,
   input  grs_data_type    rd_data,
   output logic            out_free,
   grs_rsp_if.source       rsp_if
);

   logic         valid_ff;
   grs_data_type value_ff;
   logic         done_ff;
   logic         last_ff;

   assign out_free = !valid_ff || rsp_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (out_free) begin
         valid_ff <= out_ctl.load;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ctl.load) begin
         value_ff <= rd_data;
         done_ff  <= out_ctl.list_done;
         last_ff  <= out_ctl.last_of_run;
      end
   end

   assign rsp_if.valid       = valid_ff;
   assign rsp_if.out_value   = value_ff;
   assign rsp_if.list_done   = done_ff;
   assign rsp_if.last_of_run = last_ff;

endmodule

// File: rtl/grs_checker.sv
module grs_checker import grs_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_ready,
   input logic         req_eol,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input grs_data_type rsp_value,
   input logic         rsp_done,
   input logic         rsp_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value)
         && $stable(rsp_done) && $stable(rsp_last))
      else $error("result word changed while stalled");

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done |-> rsp_last)
      else $error("list_done without last_of_run");

   a_run_no_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid)
      else $error("gap inside a result run");

   a_eol_drains: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_eol |=> !req_ready)
      else $error("end of list word did not start a drain");

endmodule

bind group_reverse_stream grs_checker u_grs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_if.valid),
   .req_ready (req_if.ready),
   .req_eol   (req_if.end_of_list),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .rsp_value (rsp_if.out_value),
   .rsp_done  (rsp_if.list_done),
   .rsp_last  (rsp_if.last_of_run)
);
